// ----- hdl/block_bounding_box_stats_defines.svh -----
// Assertion macros for the bounding-box statistics RTL.
`ifndef BLOCK_BOUNDING_BOX_STATS_DEFINES_SVH
`define BLOCK_BOUNDING_BOX_STATS_DEFINES_SVH
`ifndef SYNTH
`define BBS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bbs assertion failed");
`define BBS_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("bbs assertion failed");
`else
`define BBS_ASSERT(lbl, clk, rst_n, prop)
`define BBS_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- hdl/bbs_pkg.sv -----
// Types, constants and helpers for the bounding-box statistics block.
package bbs_pkg;

    localparam int MAX_AXES_DEF   = 8;
    localparam int COORD_BITS_DEF = 32;

    localparam int BLOCK_W    = 21;
    localparam int DIM_W      = 4;
    localparam int COUNT_W    = 40;
    localparam int AREA_W     = 63;
    localparam int AREA_LO_W  = 32;
    localparam int SIDE_SUM_W = 36;
    localparam int TOTAL_W    = 64;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = MUL_W + AREA_LO_W;
    localparam int ADDR_W     = 3;
    localparam int DATA_W     = 32;

    localparam logic [AREA_W-1:0]  AREA_LIMIT     = '1;
    localparam logic [BLOCK_W-1:0] BLK_LEN_RST    = BLOCK_W'(64);
    localparam logic [DIM_W-1:0]   DIM_COUNT_RST  = DIM_W'(2);

    // Register word index (byte address bit 2)
    localparam logic REG_BLK_LEN    = 1'b0;
    localparam logic REG_DIM_COUNT  = 1'b1;

    typedef struct packed {
        logic [31:0] coord_0;
        logic [31:0] coord_1;
        logic [31:0] coord_2;
        logic [31:0] coord_3;
        logic [31:0] coord_4;
        logic [31:0] coord_5;
        logic [31:0] coord_6;
        logic [31:0] coord_7;
        logic        end_of_stream;
    } t_point;

    typedef struct packed {
        logic [COUNT_W-1:0]    block_number;
        logic [BLOCK_W-1:0]    points_counted;
        logic [AREA_W-1:0]     block_area;
        logic [SIDE_SUM_W-1:0] block_side_sum;
        logic [TOTAL_W-1:0]    area_total;
        logic [AREA_W-1:0]     largest_area;
        logic [SIDE_SUM_W-1:0] largest_side_sum;
        logic                  stream_done;
    } t_result;

    typedef struct packed {
        logic [BLOCK_W-1:0] count;
        logic               eos;
    } t_close_info;

    function automatic logic [31:0] coord_at(t_point p, logic [2:0] d);
        logic [31:0] c;
        unique case (d)
            3'd0: c = p.coord_0;
            3'd1: c = p.coord_1;
            3'd2: c = p.coord_2;
            3'd3: c = p.coord_3;
            3'd4: c = p.coord_4;
            3'd5: c = p.coord_5;
            3'd6: c = p.coord_6;
            3'd7: c = p.coord_7;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/bbs_fifo.sv -----
// Two-entry queue that carries closed-block boxes from front to back.
module bbs_fifo import bbs_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  logic [W-1:0] i_din,
    input  logic         i_rd,
    output logic [W-1:0] o_dout,
    output logic         o_full,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_dout  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_wr) - 2'(i_rd);
        end
    end

endmodule

// ----- hdl/bbs_front.sv -----
// Front end: accepts points, tracks per-axis min/max, detects block close.
module bbs_front import bbs_pkg::*; #(
    parameter int MAX_AXES   = MAX_AXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_point                              i_point,
    input  logic                                push,
    output logic                                full,
    input  logic [BLOCK_W-1:0]                  i_blk_len,
    input  logic                                i_fifo_full,
    output logic                                o_wr,
    output logic [MAX_AXES-1:0][COORD_BITS-1:0] o_low,
    output logic [MAX_AXES-1:0][COORD_BITS-1:0] o_high,
    output t_close_info                         o_info
);

    logic [BLOCK_W-1:0]                  r_fill;
    logic [BLOCK_W-1:0]                  n_fill;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] r_low;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] r_high;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] n_low;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] n_high;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] coord;
    logic [BLOCK_W-1:0]                  fill_inc;
    logic [BLOCK_W-1:0]                  limit;
    logic                                accept;
    logic                                close;
    logic                                first;

    // Hold off the whole beat while the queue is full
    assign full   = i_fifo_full;
    assign accept = push && !i_fifo_full;

    for (genvar d = 0; d < MAX_AXES; d++) begin : g_axis
        assign coord[d] = COORD_BITS'(coord_at(i_point, 3'(d)));
    end

    always_comb begin
        first = (r_fill == '0);
        for (int d = 0; d < MAX_AXES; d++) begin
            n_low[d]  = (first || coord[d] < r_low[d])  ? coord[d] : r_low[d];
            n_high[d] = (first || coord[d] > r_high[d]) ? coord[d] : r_high[d];
        end
        fill_inc = r_fill + 1'b1;
        limit    = (i_blk_len == '0) ? BLOCK_W'(1) : i_blk_len;
        close    = (fill_inc >= limit) || i_point.end_of_stream;
        n_fill   = close ? '0 : fill_inc;
    end

    assign o_wr        = accept && close;
    assign o_low       = n_low;
    assign o_high      = n_high;
    assign o_info.count = fill_inc;
    assign o_info.eos   = i_point.end_of_stream;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_low  <= n_low;
            r_high <= n_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
        end
    end

endmodule

// ----- hdl/bbs_back.sv -----
// Back end: side lengths, saturating area product, stream totals, result slot.
`include "block_bounding_box_stats_defines.svh"
module bbs_back import bbs_pkg::*; #(
    parameter int MAX_AXES   = MAX_AXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fifo_empty,
    output logic                                o_rd,
    input  logic [MAX_AXES-1:0][COORD_BITS-1:0] i_low,
    input  logic [MAX_AXES-1:0][COORD_BITS-1:0] i_high,
    input  t_close_info                         i_info,
    input  logic [DIM_W-1:0]                    i_dim_count,
    input  logic                                pop,
    output logic                                empty,
    output t_result                             o_result
);

    localparam int CNT_W  = $clog2(MAX_AXES + 1);
    localparam int SIDE_W = COORD_BITS + 1;
    localparam int SUM_W  = AREA_W + 3;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SIDE = 3'd1;
    localparam logic [2:0] S_MLO  = 3'd2;
    localparam logic [2:0] S_MHI  = 3'd3;
    localparam logic [2:0] S_COMB = 3'd4;
    localparam logic [2:0] S_TOT  = 3'd5;

    logic [2:0]                          r_state;
    logic [2:0]                          n_state;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] r_lo;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] r_hi;
    t_close_info                         r_info;
    logic [CNT_W-1:0]                    r_left;
    logic [SIDE_W-1:0]                   r_side;
    logic [AREA_W-1:0]                   r_area;
    logic [SIDE_SUM_W-1:0]               r_sides;
    logic [PROD_W-1:0]                   r_plo;
    logic [PROD_W-1:0]                   r_phi;
    logic [COUNT_W-1:0]                  r_blocks;
    logic [TOTAL_W-1:0]                  r_asum;
    logic [AREA_W-1:0]                   r_apeak;
    logic [SIDE_SUM_W-1:0]               r_speak;
    logic                                r_out_valid;
    t_result                             r_out;

    logic [CNT_W-1:0]      axes;
    logic [SIDE_W-1:0]     side;
    logic [AREA_LO_W-1:0]  mul_a;
    logic [MUL_W-1:0]      mul_b;
    logic [PROD_W-1:0]     mul_p;
    logic [SUM_W-1:0]      lowsum;
    logic                  sat;
    logic [TOTAL_W:0]      tot_sum;
    logic [TOTAL_W-1:0]    n_asum;
    logic [AREA_W-1:0]     n_apeak;
    logic [SIDE_SUM_W-1:0] n_speak;
    logic                  out_load;
    t_result               result;

    assign axes = ({28'd0, i_dim_count} > MAX_AXES) ? CNT_W'(MAX_AXES) : CNT_W'(i_dim_count);
    assign o_rd = (r_state == S_IDLE) && !i_fifo_empty;

    // Full-range axis gives 2^COORD_BITS, hence the extra bit
    assign side = {1'b0, r_hi[0]} - {1'b0, r_lo[0]} + SIDE_W'(1);

    // One shared 32x33 multiplier: low half of area, then high half
    assign mul_a = (r_state == S_MLO) ? r_area[AREA_LO_W-1:0]
                                      : AREA_LO_W'(r_area[AREA_W-1:AREA_LO_W]);
    assign mul_b = MUL_W'(r_side);
    assign mul_p = mul_a * mul_b;

    assign lowsum = SUM_W'({r_phi[AREA_W-AREA_LO_W-1:0], {AREA_LO_W{1'b0}}})
                  + SUM_W'(r_plo);
    assign sat    = (|r_phi[PROD_W-1:AREA_W-AREA_LO_W]) || (|lowsum[SUM_W-1:AREA_W]);

    assign tot_sum  = {1'b0, r_asum} + (TOTAL_W+1)'(r_area);
    assign n_asum   = tot_sum[TOTAL_W] ? '1 : tot_sum[TOTAL_W-1:0];
    assign n_apeak  = (r_area > r_apeak) ? r_area : r_apeak;
    assign n_speak  = (r_sides > r_speak) ? r_sides : r_speak;
    assign out_load = (r_state == S_TOT) && (!r_out_valid || pop);

    always_comb begin
        result.block_number     = r_blocks;
        result.points_counted   = r_info.count;
        result.block_area       = r_area;
        result.block_side_sum   = r_sides;
        result.area_total       = n_asum;
        result.largest_area     = n_apeak;
        result.largest_side_sum = n_speak;
        result.stream_done      = r_info.eos;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_fifo_empty) begin
                    n_state = (axes == '0) ? S_TOT : S_SIDE;
                end
            end
            S_SIDE: n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_COMB;
            S_COMB: n_state = (r_left == CNT_W'(1)) ? S_TOT : S_SIDE;
            S_TOT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            r_lo    <= i_low;
            r_hi    <= i_high;
            r_info  <= i_info;
            r_area  <= AREA_W'(1);
            r_sides <= '0;
        end
        if (r_state == S_SIDE) begin
            r_side <= side;
            // Advance the next axis into lane zero
            for (int d = 0; d < MAX_AXES - 1; d++) begin
                r_lo[d] <= r_lo[d+1];
                r_hi[d] <= r_hi[d+1];
            end
        end
        if (r_state == S_MLO) begin
            r_plo <= mul_p;
        end
        if (r_state == S_MHI) begin
            r_phi <= mul_p;
        end
        if (r_state == S_COMB) begin
            r_area  <= sat ? AREA_LIMIT : lowsum[AREA_W-1:0];
            r_sides <= r_sides + SIDE_SUM_W'(r_side);
        end
        if (out_load) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_blocks    <= '0;
            r_asum      <= '0;
            r_apeak     <= '0;
            r_speak     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_rd) begin
                r_left <= axes;
            end else if (r_state == S_COMB) begin
                r_left <= r_left - 1'b1;
            end
            if (out_load) begin
                // Drop the stream totals once the last block is out
                if (r_info.eos) begin
                    r_blocks <= '0;
                    r_asum   <= '0;
                    r_apeak  <= '0;
                    r_speak  <= '0;
                end else begin
                    r_blocks <= r_blocks + 1'b1;
                    r_asum   <= n_asum;
                    r_apeak  <= n_apeak;
                    r_speak  <= n_speak;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign empty    = !r_out_valid;
    assign o_result = r_out;

    `BBS_ASSERT(a_area_nonzero, i_clk, i_rst_n, (r_state != S_IDLE) |-> (r_area != '0))
    `BBS_ASSERT(a_axes_left, i_clk, i_rst_n, (r_state == S_SIDE || r_state == S_MLO || r_state == S_MHI || r_state == S_COMB) |-> (r_left != '0))
    `BBS_ASSERT(a_eos_clears, i_clk, i_rst_n, (out_load && r_info.eos) |=> (r_blocks == '0 && r_asum == '0 && r_apeak == '0 && r_speak == '0))
    `BBS_ASSERT(a_peak_bounds, i_clk, i_rst_n, r_out_valid |-> (r_out.largest_area >= r_out.block_area && r_out.area_total >= TOTAL_W'(r_out.block_area)))
    `BBS_NEVER(a_no_pop_in_work, i_clk, i_rst_n, o_rd && (r_state != S_IDLE))

endmodule

// ----- hdl/block_bounding_box_stats.sv -----
// Top level of the per-block bounding-box statistics block.
// Points: one beat a cycle while the front queue has room (two closed blocks).
// Each closed block steps in the back end through the side, low-product, high-product
// and combine states once per axis in use (one shared 32x33 multiplier pass for each
// half of the area per axis), then a totals state that waits while the result slot is full.
// Synchronous active-low reset: counters and totals clear, block length 64, dim_count 2.
module block_bounding_box_stats import bbs_pkg::*; #(
    parameter int MAX_AXES   = MAX_AXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_point            i_point,
    input  logic              push,
    output logic              full,
    output t_result           o_result,
    output logic              empty,
    input  logic              pop,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int REC_W = 2 * MAX_AXES * COORD_BITS + $bits(t_close_info);

    logic [BLOCK_W-1:0] r_blk_len;
    logic [DIM_W-1:0]   r_dim_count;
    logic               cfg_wr;

    logic                                f_wr;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] f_low;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] f_high;
    t_close_info                         f_info;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] q_low;
    logic [MAX_AXES-1:0][COORD_BITS-1:0] q_high;
    t_close_info                         q_info;
    logic [REC_W-1:0]                    q_dout;
    logic                                q_full;
    logic                                q_empty;
    logic                                q_rd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk_len    <= BLK_LEN_RST;
            r_dim_count  <= DIM_COUNT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_BLK_LEN:    r_blk_len    <= pwdata[BLOCK_W-1:0];
                REG_DIM_COUNT:  r_dim_count  <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            unique case (paddr[2])
                REG_BLK_LEN:    prdata = DATA_W'(r_blk_len);
                REG_DIM_COUNT:  prdata = DATA_W'(r_dim_count);
            endcase
        end
    end

    bbs_front #(
        .MAX_AXES   (MAX_AXES),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_point      (i_point),
        .push         (push),
        .full         (full),
        .i_blk_len    (r_blk_len),
        .i_fifo_full  (q_full),
        .o_wr         (f_wr),
        .o_low        (f_low),
        .o_high       (f_high),
        .o_info       (f_info)
    );

    bbs_fifo #(
        .W (REC_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_wr),
        .i_din   ({f_low, f_high, f_info}),
        .i_rd    (q_rd),
        .o_dout  (q_dout),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign {q_low, q_high, q_info} = q_dout;

    bbs_back #(
        .MAX_AXES   (MAX_AXES),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fifo_empty (q_empty),
        .o_rd         (q_rd),
        .i_low        (q_low),
        .i_high       (q_high),
        .i_info       (q_info),
        .i_dim_count  (r_dim_count),
        .pop          (pop),
        .empty        (empty),
        .o_result     (o_result)
    );

endmodule
